// ===== sv/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// sss_pkg
// Shared widths, constants and controller/datapath interface types for the
// selective state scan block.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int DEF_INNER_CHANNELS = 512;
  localparam int DEF_STATE_DEPTH    = 16;

  localparam int CH_W   = 9;
  localparam int SIDX_W = 4;
  localparam int CFG_W  = 5;
  localparam int DAT_W  = 16;
  localparam int HID_W  = 24;
  localparam int SUM_W  = 32;
  localparam int CMP_W  = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  typedef struct packed {
    logic load;
    logic rd;
    logic mul;
    logic upd;
    logic wmul;
    logic acc;
  } sss_cmd_t;

  typedef struct packed {
    logic item_ok;
    logic last;
    logic out_busy;
  } sss_sts_t;

endpackage

// ===== sv/sss_ctrl.sv =====
// ----------------------------------------------------------------------------
// sss_ctrl
// Sequencer for one request: accept, hidden read, decay multiply, hidden
// update and write back, weight multiply, and sum update with result hand-off.
// ----------------------------------------------------------------------------
module sss_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  sss_pkg::sss_sts_t sts,
  output sss_pkg::sss_cmd_t cmd
);
  import sss_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_WMUL = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;
  logic       blocked;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign blocked  = (state_r == S_ACC) && sts.last && sts.out_busy;

  always_comb begin
    cmd      = '0;
    cmd.load = accept;
    cmd.rd   = (state_r == S_RD);
    cmd.mul  = (state_r == S_MUL);
    cmd.upd  = (state_r == S_UPD);
    cmd.wmul = (state_r == S_WMUL);
    cmd.acc  = (state_r == S_ACC) && !blocked;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && sts.item_ok) begin
          state_nxt = S_RD;
        end
      end
      S_RD:   state_nxt = S_MUL;
      S_MUL:  state_nxt = S_UPD;
      S_UPD:  state_nxt = S_WMUL;
      S_WMUL: state_nxt = S_ACC;
      S_ACC: begin
        if (!blocked) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && sts.item_ok |=> state_r == S_RD)
    else $error("accepted element did not start the read");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc && sts.last |-> !sts.out_busy)
    else $error("pending result overwritten");

  a_blocked_holds: assert property (@(posedge clk) disable iff (!rst_n)
    blocked |=> state_r == S_ACC)
    else $error("left the sum step while the result was held");

  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.rd, cmd.mul, cmd.upd, cmd.wmul, cmd.acc}))
    else $error("more than one datapath step at once");

endmodule

// ===== sv/sss_dp.sv =====
// ----------------------------------------------------------------------------
// sss_dp
// Datapath: request registers, hidden store memory, the two multiply stages,
// rounding and saturation, the running sum and the result register.
// ----------------------------------------------------------------------------
module sss_dp #(
  parameter int INNER_CHANNELS = sss_pkg::DEF_INNER_CHANNELS,
  parameter int STATE_DEPTH    = sss_pkg::DEF_STATE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  sss_pkg::sss_cmd_t                cmd,
  output sss_pkg::sss_sts_t                sts,
  input  logic                             cfg_we,
  input  logic        [sss_pkg::CFG_W-1:0] cfg_wdata,
  input  logic        [sss_pkg::CH_W-1:0]  in_channel,
  input  logic        [sss_pkg::SIDX_W-1:0] in_state_index,
  input  logic                             in_first_step,
  input  logic        [sss_pkg::DAT_W-1:0] in_decay,
  input  logic signed [sss_pkg::DAT_W-1:0] in_gain,
  input  logic signed [sss_pkg::DAT_W-1:0] in_weight,
  input  logic signed [sss_pkg::DAT_W-1:0] in_x_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic        [sss_pkg::CH_W-1:0]  out_channel,
  output logic signed [sss_pkg::SUM_W-1:0] out_y_value,
  output logic                             out_saturated
);
  import sss_pkg::*;

  localparam int Depth = INNER_CHANNELS * STATE_DEPTH;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic signed [HID_W-1:0] mem [Depth];

  logic [CFG_W-1:0]  cfg_r;
  logic [CMP_W-1:0]  used_eff;
  logic [CMP_W-1:0]  sidx_ext;
  logic              ch_ok;
  logic              in_last;

  logic [CH_W-1:0]          ch_r;
  logic [AddrW-1:0]         addr_r;
  logic                     first_r;
  logic                     start_r;
  logic                     last_r;
  logic [DAT_W-1:0]         decay_r;
  logic signed [DAT_W-1:0]  gain_r;
  logic signed [DAT_W-1:0]  weight_r;
  logic signed [DAT_W-1:0]  x_r;

  logic signed [HID_W-1:0]  rd_data_r;
  logic signed [31:0]       gx_r;
  logic signed [HID_W-1:0]  prev;
  logic signed [40:0]       dp_r;
  logic signed [41:0]       acc;
  logic signed [41:0]       acc_rnd;
  logic signed [26:0]       h_wide;
  logic signed [HID_W-1:0]  h_sat;
  logic                     h_ovf;
  logic signed [HID_W-1:0]  h_r;
  logic signed [39:0]       wp_r;
  logic signed [39:0]       wp_rnd;
  logic signed [27:0]       term;
  logic signed [SUM_W-1:0]  sum_base;
  logic signed [SUM_W:0]    sum_wide;
  logic signed [SUM_W-1:0]  sum_sat;
  logic                     sum_ovf;

  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic                     sat_r;
  logic                     sat_nxt;
  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [CH_W-1:0]          out_ch_r;
  logic signed [SUM_W-1:0]  out_y_r;
  logic                     out_sat_r;

  always_comb begin
    if (cfg_r == '0) begin
      used_eff = CMP_W'(1);
    end else if (CMP_W'(cfg_r) > CMP_W'(STATE_DEPTH)) begin
      used_eff = CMP_W'(STATE_DEPTH);
    end else begin
      used_eff = CMP_W'(cfg_r);
    end
  end

  assign sidx_ext     = CMP_W'(in_state_index);
  assign ch_ok        = 32'(in_channel) < 32'(INNER_CHANNELS);
  assign in_last      = (sidx_ext + CMP_W'(1)) == used_eff;
  assign sts.item_ok  = ch_ok && (sidx_ext < used_eff);
  assign sts.last     = last_r;
  assign sts.out_busy = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ch_r     <= in_channel;
      addr_r   <= AddrW'(32'(in_channel) * 32'(STATE_DEPTH) + 32'(in_state_index));
      first_r  <= in_first_step;
      start_r  <= (in_state_index == '0);
      last_r   <= in_last;
      decay_r  <= in_decay;
      gain_r   <= in_gain;
      weight_r <= in_weight;
      x_r      <= in_x_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= mem[addr_r];
    end
    if (cmd.upd) begin
      mem[addr_r] <= h_sat;
    end
  end

  assign prev = first_r ? '0 : rd_data_r;

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      gx_r <= gain_r * x_r;
    end
    if (cmd.mul) begin
      dp_r <= $signed({1'b0, decay_r}) * prev;
    end
    if (cmd.upd) begin
      h_r <= h_sat;
    end
    if (cmd.wmul) begin
      wp_r <= weight_r * h_r;
    end
  end

  always_comb begin
    acc     = {dp_r[40], dp_r} + {{7{gx_r[31]}}, gx_r, 3'b000};
    acc_rnd = acc + 42'sd16384;
    h_wide  = acc_rnd[41:15];
    h_ovf   = 1'b1;
    if (h_wide > 27'sd8388607) begin
      h_sat = {1'b0, {(HID_W-1){1'b1}}};
    end else if (h_wide < -27'sd8388608) begin
      h_sat = {1'b1, {(HID_W-1){1'b0}}};
    end else begin
      h_sat = h_wide[HID_W-1:0];
      h_ovf = 1'b0;
    end
  end

  always_comb begin
    wp_rnd   = wp_r + 40'sd2048;
    term     = wp_rnd[39:12];
    sum_base = start_r ? '0 : sum_r;
    sum_wide = {sum_base[SUM_W-1], sum_base} + {{(SUM_W-27){term[27]}}, term};
    sum_ovf  = sum_wide[SUM_W] != sum_wide[SUM_W-1];
    if (!sum_ovf) begin
      sum_sat = sum_wide[SUM_W-1:0];
    end else if (sum_wide[SUM_W]) begin
      sum_sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  always_comb begin
    sum_nxt       = sum_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.upd) begin
      sat_nxt = (start_r ? 1'b0 : sat_r) | h_ovf;
    end
    if (cmd.acc) begin
      if (last_r) begin
        sum_nxt       = '0;
        sat_nxt       = 1'b0;
        out_valid_nxt = 1'b1;
      end else begin
        sum_nxt = sum_sat;
        sat_nxt = sat_r | sum_ovf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      sum_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      sum_r       <= sum_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc && last_r) begin
      out_ch_r  <= ch_r;
      out_y_r   <= sum_sat;
      out_sat_r <= sat_r | sum_ovf;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_channel   = out_ch_r;
  assign out_y_value   = out_y_r;
  assign out_saturated = out_sat_r;

endmodule

// ===== sv/selective_state_scan.sv =====
// ----------------------------------------------------------------------------
// selective_state_scan
// Diagonal state-space scan step: per-channel, per-state hidden update with
// a saturating weighted sum emitted after the last state index in use.
// ----------------------------------------------------------------------------
// Each request in range goes from its accept cycle through the hidden store
// read, the decay multiply, the hidden update with write back, the weight
// multiply and the sum update before the next one can be accepted; these
// steps form one dependent chain of states through the single-port hidden
// store. A request whose channel or state index is out of range is dropped
// in its accept cycle. A finished channel output waits in an output register
// while the next requests are taken; only a closing request that finds that
// register still held waits in its sum step. The hidden store has no reset,
// so each entry must be started with first_step before it is continued.
module selective_state_scan #(
  parameter int INNER_CHANNELS = sss_pkg::DEF_INNER_CHANNELS,
  parameter int STATE_DEPTH    = sss_pkg::DEF_STATE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic        [sss_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic        [sss_pkg::CH_W-1:0]   in_channel,
  input  logic        [sss_pkg::SIDX_W-1:0] in_state_index,
  input  logic                              in_first_step,
  input  logic        [sss_pkg::DAT_W-1:0]  in_decay,
  input  logic signed [sss_pkg::DAT_W-1:0]  in_gain,
  input  logic signed [sss_pkg::DAT_W-1:0]  in_weight,
  input  logic signed [sss_pkg::DAT_W-1:0]  in_x_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic        [sss_pkg::CH_W-1:0]   out_channel,
  output logic signed [sss_pkg::SUM_W-1:0]  out_y_value,
  output logic                              out_saturated
);
  import sss_pkg::*;

  sss_cmd_t cmd;
  sss_sts_t sts;

  sss_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sss_dp #(
    .INNER_CHANNELS (INNER_CHANNELS),
    .STATE_DEPTH    (STATE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_channel     (in_channel),
    .in_state_index (in_state_index),
    .in_first_step  (in_first_step),
    .in_decay       (in_decay),
    .in_gain        (in_gain),
    .in_weight      (in_weight),
    .in_x_value     (in_x_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel    (out_channel),
    .out_y_value    (out_y_value),
    .out_saturated  (out_saturated)
  );

endmodule

// ===== dv/selective_state_scan_tb.sv =====
// ----------------------------------------------------------------------------
// selective_state_scan_tb
// Self-checking bench for the selective state scan block. Elements are
// queued by a sequencer, offered by a clocked driver and checked by a clocked
// monitor against an in-bench model of the hidden store and running sum.
// A directed opener is followed by randomized channel sweeps under several
// state sizes and handshake idling patterns, with one long output hold-off.
// ----------------------------------------------------------------------------
module selective_state_scan_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sss_pkg::*;

  localparam int     HID_DEPTH      = DEF_INNER_CHANNELS * DEF_STATE_DEPTH;
  localparam int     DRAIN_CYCLES   = 12;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     LONG_HOLD      = 300;
  localparam int     HOLD_PHASE     = 6;
  localparam longint HID_MAX        = 64'sd8388607;
  localparam longint HID_MIN        = -64'sd8388608;
  localparam longint SUM_MAX        = 64'sd2147483647;
  localparam longint SUM_MIN        = -64'sd2147483648;

  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [SIDX_W-1:0] sidx;
    logic              first;
    logic [DAT_W-1:0]  decay;
    logic [DAT_W-1:0]  gain;
    logic [DAT_W-1:0]  weight;
    logic [DAT_W-1:0]  x_value;
  } scan_elem_t;

  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SUM_W-1:0] y_value;
    logic             saturated;
  } chan_out_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic        [CFG_W-1:0]  cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic        [CH_W-1:0]   in_channel = '0;
  logic        [SIDX_W-1:0] in_state_index = '0;
  logic                     in_first_step = 1'b0;
  logic        [DAT_W-1:0]  in_decay = '0;
  logic signed [DAT_W-1:0]  in_gain = '0;
  logic signed [DAT_W-1:0]  in_weight = '0;
  logic signed [DAT_W-1:0]  in_x_value = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic        [CH_W-1:0]   out_channel;
  logic signed [SUM_W-1:0]  out_y_value;
  logic                     out_saturated;

  selective_state_scan DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_channel     (in_channel),
    .in_state_index (in_state_index),
    .in_first_step  (in_first_step),
    .in_decay       (in_decay),
    .in_gain        (in_gain),
    .in_weight      (in_weight),
    .in_x_value     (in_x_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_channel    (out_channel),
    .out_y_value    (out_y_value),
    .out_saturated  (out_saturated)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  scan_elem_t              pending_elems[$];
  chan_out_t               expected_outs[$];
  scan_elem_t              cur_elem;
  chan_out_t               drv_out;
  chan_out_t               mon_exp;
  int                      elems_queued = 0;
  int                      elems_taken = 0;
  int                      err_cnt = 0;
  int                      send_idle_pct = 0;
  int                      recv_idle_pct = 0;
  int                      phase_no = -1;
  int                      hold_left = 0;
  bit                      long_hold_done = 1'b0;
  int                      quiet_cycles = 0;
  int                      gen_used = 16;
  bit                      hid_written [0:HID_DEPTH-1];

  logic        [CFG_W-1:0] size_reg = CFG_RESET;
  logic signed [HID_W-1:0] hidden_model [0:HID_DEPTH-1];
  logic signed [SUM_W-1:0] run_sum = '0;
  logic                    run_sat = 1'b0;

  function automatic int clamp_size(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > DEF_STATE_DEPTH) return DEF_STATE_DEPTH;
    return int'(v);
  endfunction

  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic bit predict_element(input scan_elem_t e, output chan_out_t r);
    int          used;
    logic [12:0] addr;
    longint      prev;
    longint      acc;
    longint      hnew;
    longint      term;
    longint      sum;
    used = clamp_size(size_reg);
    r = '0;
    if (e.sidx >= used) return 1'b0;
    addr = {e.channel, e.sidx};
    if (e.sidx == 0) begin
      run_sum = '0;
      run_sat = 1'b0;
    end
    prev = e.first ? 64'sd0 : longint'(hidden_model[addr]);
    acc = longint'(e.decay) * prev
        + longint'($signed(e.gain)) * longint'($signed(e.x_value)) * 8;
    hnew = rnd_shift(acc, 15);
    if (hnew > HID_MAX) begin
      hnew = HID_MAX;
      run_sat = 1'b1;
    end else if (hnew < HID_MIN) begin
      hnew = HID_MIN;
      run_sat = 1'b1;
    end
    hidden_model[addr] = hnew[HID_W-1:0];
    term = rnd_shift(longint'($signed(e.weight)) * hnew, 12);
    sum = longint'(run_sum) + term;
    if (sum > SUM_MAX) begin
      sum = SUM_MAX;
      run_sat = 1'b1;
    end else if (sum < SUM_MIN) begin
      sum = SUM_MIN;
      run_sat = 1'b1;
    end
    run_sum = sum[SUM_W-1:0];
    if (e.sidx != used - 1) return 1'b0;
    r.channel = e.channel;
    r.y_value = run_sum;
    r.saturated = run_sat;
    run_sum = '0;
    run_sat = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 100) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic void push_elem(input int ch, input int s, input bit first,
                                    input logic [DAT_W-1:0] d, input logic [DAT_W-1:0] g,
                                    input logic [DAT_W-1:0] w, input logic [DAT_W-1:0] x);
    scan_elem_t e;
    e.channel = ch[CH_W-1:0];
    e.sidx = s[SIDX_W-1:0];
    e.first = first;
    e.decay = d;
    e.gain = g;
    e.weight = w;
    e.x_value = x;
    if (s < gen_used) hid_written[{e.channel, e.sidx}] = 1'b1;
    pending_elems = {pending_elems, e};
    elems_queued++;
  endfunction

  function automatic logic [DAT_W-1:0] pick_data();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7FFF;
    if (r == 2) return 16'h0000;
    return DAT_W'($urandom_range(16'hFFFF));
  endfunction

  function automatic logic [DAT_W-1:0] pick_decay();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'h8000;
    if (r == 2) return 16'hFFFF;
    if (r == 3) return DAT_W'($urandom_range(16'hFFFF, 16'h8001));
    return DAT_W'($urandom_range(16'h8000, 16'd20000));
  endfunction

  function automatic void push_random(input int ch, input int s);
    bit first;
    bit in_use;
    in_use = (s < gen_used);
    if (in_use && !hid_written[{ch[CH_W-1:0], s[SIDX_W-1:0]}]) first = 1'b1;
    else first = ($urandom_range(5) == 0);
    push_elem(ch, s, first, pick_decay(), pick_data(), pick_data(), pick_data());
  endfunction

  task automatic gen_random(input int target);
    int made;
    int kind;
    int ch;
    int start;
    int stop;
    int s;
    made = 0;
    while (made < target) begin
      kind = $urandom_range(99);
      ch = $urandom_range(1) ? $urandom_range(3) : $urandom_range(DEF_INNER_CHANNELS - 1);
      if (kind < 75) begin
        for (s = 0; s < gen_used; s++) begin
          push_random(ch, s);
          made++;
        end
      end else if (kind < 88) begin
        start = $urandom_range(gen_used - 1);
        stop = $urandom_range(DEF_STATE_DEPTH - 1, start);
        for (s = start; s <= stop; s++) begin
          push_random(ch, s);
          if (s < gen_used) made++;
        end
      end else begin
        s = $urandom_range(DEF_STATE_DEPTH - 1);
        push_random(ch, s);
        if (s < gen_used) made++;
      end
    end
  endtask

  task automatic wait_drained();
    while (elems_taken != elems_queued || expected_outs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_size(input logic [CFG_W-1:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    size_reg = v;
    gen_used = clamp_size(v);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (predict_element(cur_elem, drv_out)) expected_outs = {expected_outs, drv_out};
        elems_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_elems.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_elem = pending_elems.pop_front();
          in_channel <= cur_elem.channel;
          in_state_index <= cur_elem.sidx;
          in_first_step <= cur_elem.first;
          in_decay <= cur_elem.decay;
          in_gain <= cur_elem.gain;
          in_weight <= cur_elem.weight;
          in_x_value <= cur_elem.x_value;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_outs.size() == 0) begin
          report_mismatch($sformatf("unexpected result ch=%0d y=%0d", out_channel,
                                    out_y_value));
        end else begin
          mon_exp = expected_outs.pop_front();
          if (out_channel !== mon_exp.channel)
            report_mismatch($sformatf("out_channel got %0d exp %0d", out_channel,
                                      mon_exp.channel));
          if (out_y_value !== $signed(mon_exp.y_value))
            report_mismatch($sformatf("y_value got %0d exp %0d", out_y_value,
                                      $signed(mon_exp.y_value)));
          if (out_saturated !== mon_exp.saturated)
            report_mismatch($sformatf("saturated got %0b exp %0b", out_saturated,
                                      mon_exp.saturated));
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!long_hold_done && phase_no == HOLD_PHASE && out_valid) begin
        hold_left <= LONG_HOLD;
        long_hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] phase_size [0:8];
    phase_size = '{5'd16, 5'd1, 5'd5, 5'd0, 5'd31, 5'd0, 5'd3, 5'd16, 5'd0};
    phase_size[5] = CFG_W'($urandom_range(31));
    phase_size[8] = CFG_W'($urandom_range(31));
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Two-element sums for the directed opener.
    write_size(5'd2);
    push_elem(0, 0, 1'b1, 16'h0000, 16'h8000, 16'h8000, 16'h8000);
    push_elem(0, 1, 1'b1, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    push_elem(3, 0, 1'b1, 16'hFFFF, 16'h7FFF, 16'h0000, 16'h7FFF);
    push_elem(511, 1, 1'b1, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
    push_elem(511, 15, 1'b1, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_elem(7, 2, 1'b0, 16'h1234, 16'h4321, 16'h5555, 16'hAAAA);
    push_elem(0, 0, 1'b1, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_elem(0, 0, 1'b0, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    push_elem(0, 1, 1'b0, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000);
    // Growing decay drives both hidden entries into saturation.
    for (int i = 0; i < 6; i++) begin
      push_elem(0, 0, 1'b0, 16'hFFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      push_elem(0, 1, 1'b0, 16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF);
    end
    wait_drained();

    for (int p = 0; p < 9; p++) begin
      if (p < 3) begin
        send_idle_pct = 30;
        recv_idle_pct = 61;
      end else if (p < 6) begin
        send_idle_pct = 61;
        recv_idle_pct = 30;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_size(phase_size[p]);
      phase_no = p;
      gen_random(55);
      wait_drained();
      gen_random(55);
      wait_drained();
    end

    if (expected_outs.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_outs.size()));
    if (err_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sss_pkg.sv
sv/sss_ctrl.sv
sv/sss_dp.sv
sv/selective_state_scan.sv
dv/selective_state_scan_tb.sv
